### rtl/rrc_pkg.sv
// Package for the rotor and reflector cipher: widths, register indexes, table type
// and the symbol mapping functions. It depends on nothing else.
`timescale 1ns / 1ps

package rrc_pkg;

	localparam int SYMBOLS = 30;
	localparam int POS_W   = 5;
	localparam int CHAR_W  = 8;
	localparam int REG_W   = 50;
	localparam int IDX_W   = 3;
	localparam int PER_REG = 10;

	localparam logic [POS_W-1:0] LAST_POS = 5'd29;

	typedef enum logic [IDX_W-1:0] {
		CFG_ROTOR_0 = 3'd0,
		CFG_ROTOR_1 = 3'd1,
		CFG_ROTOR_2 = 3'd2,
		CFG_REFL_0  = 3'd3,
		CFG_REFL_1  = 3'd4,
		CFG_REFL_2  = 3'd5
	} cfg_reg_t;

	typedef logic [SYMBOLS-1:0][POS_W-1:0] table_t;

	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] pos;
	} sym_t;

	function automatic logic [POS_W-1:0] wrap_pos(input logic [POS_W-1:0] v);
		wrap_pos = (v >= 5'd30) ? v - 5'd30 : v;
	endfunction

	function automatic sym_t sym_index(input logic [CHAR_W-1:0] c);
		sym_t s;
		s.hit = 1'b1;
		s.pos = '0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			s.pos = POS_W'(c - 8'h41);
		end else begin
			case (c)
				8'h2E:   s.pos = 5'd26;
				8'h2C:   s.pos = 5'd27;
				8'h27:   s.pos = 5'd28;
				8'h20:   s.pos = 5'd29;
				default: s.hit = 1'b0;
			endcase
		end
		sym_index = s;
	endfunction

	function automatic logic [CHAR_W-1:0] sym_char(input logic [POS_W-1:0] q);
		logic [CHAR_W-1:0] c;
		c = 8'h20;
		if (q < 5'd26) begin
			c = 8'h41 + {3'b000, q};
		end else begin
			case (q)
				5'd26:   c = 8'h2E;
				5'd27:   c = 8'h2C;
				5'd28:   c = 8'h27;
				default: c = 8'h20;
			endcase
		end
		sym_char = c;
	endfunction

endpackage

### rtl/rrc_channels.sv
// Channel interfaces of the cipher: character input, result output and register writes.
// Widths come from rrc_pkg.
`timescale 1ns / 1ps

interface rrc_in_if;
	logic                       valid;
	logic                       ready;
	logic [rrc_pkg::CHAR_W-1:0] char_in;
	logic                       restart;
	modport source (output valid, char_in, restart, input ready);
	modport sink (input valid, char_in, restart, output ready);
endinterface

interface rrc_out_if;
	logic                       valid;
	logic                       ready;
	logic [rrc_pkg::CHAR_W-1:0] char_out;
	logic                       invalid;
	modport source (output valid, char_out, invalid, input ready);
	modport sink (input valid, char_out, invalid, output ready);
endinterface

interface rrc_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [rrc_pkg::IDX_W-1:0] index;
	logic [rrc_pkg::REG_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/rrc_cfg_regs.sv
// Configuration register file of the cipher, presenting the rotor and reflector tables
// with out-of-range entries wrapped. Depends on rrc_pkg and rrc_channels.
`timescale 1ns / 1ps

module rrc_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	rrc_cfg_if.sink        cfg,
	output rrc_pkg::table_t rotor,
	output rrc_pkg::table_t refl
);

	logic [2:0][rrc_pkg::REG_W-1:0] rotor_q;
	logic [2:0][rrc_pkg::REG_W-1:0] refl_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_q <= '0;
			refl_q  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				rrc_pkg::CFG_ROTOR_0: rotor_q[0] <= cfg.data;
				rrc_pkg::CFG_ROTOR_1: rotor_q[1] <= cfg.data;
				rrc_pkg::CFG_ROTOR_2: rotor_q[2] <= cfg.data;
				rrc_pkg::CFG_REFL_0:  refl_q[0]  <= cfg.data;
				rrc_pkg::CFG_REFL_1:  refl_q[1]  <= cfg.data;
				rrc_pkg::CFG_REFL_2:  refl_q[2]  <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int k = 0; k < rrc_pkg::SYMBOLS; k++) begin
			rotor[k] = rrc_pkg::wrap_pos(
				rotor_q[k / rrc_pkg::PER_REG][(k % rrc_pkg::PER_REG) * rrc_pkg::POS_W +:
				rrc_pkg::POS_W]);
			refl[k] = rrc_pkg::wrap_pos(
				refl_q[k / rrc_pkg::PER_REG][(k % rrc_pkg::PER_REG) * rrc_pkg::POS_W +:
				rrc_pkg::POS_W]);
		end
	end

endmodule

### rtl/rrc_datapath.sv
// Cipher datapath: rotor offset, input stage, table lookups, rotor search and result
// register. Depends on rrc_pkg and rrc_channels.
`timescale 1ns / 1ps

module rrc_datapath (
	input  logic            clk,
	input  logic            arst_n,
	rrc_in_if.sink          din,
	rrc_out_if.source       dout,
	input  rrc_pkg::table_t rotor,
	input  rrc_pkg::table_t refl
);

	logic [rrc_pkg::POS_W-1:0]  offset_q;
	logic [rrc_pkg::POS_W-1:0]  base_off;
	logic [rrc_pkg::POS_W-1:0]  step_off;
	rrc_pkg::sym_t              sym;
	logic                       in_take;
	logic                       adv_s1;

	logic                       valid_s1;
	logic                       hit_s1;
	logic [rrc_pkg::POS_W-1:0]  pos_s1;
	logic [rrc_pkg::POS_W-1:0]  off_s1;

	logic                       valid_s2;
	logic                       invalid_s2;
	logic [rrc_pkg::CHAR_W-1:0] char_s2;

	logic [rrc_pkg::POS_W:0]    sp_sum;
	logic [rrc_pkg::POS_W-1:0]  sp;
	logic [rrc_pkg::POS_W-1:0]  p;
	logic [rrc_pkg::POS_W-1:0]  r;
	logic [rrc_pkg::POS_W-1:0]  q;
	logic [rrc_pkg::POS_W:0]    q_sum;
	logic [rrc_pkg::POS_W-1:0]  out_pos;

	assign adv_s1    = !valid_s2 || dout.ready;
	assign din.ready = !valid_s1 || adv_s1;
	assign in_take   = din.valid && din.ready;

	assign base_off = din.restart ? '0 : offset_q;
	assign step_off = (base_off == rrc_pkg::LAST_POS) ? '0 : base_off + 1'b1;
	assign sym      = rrc_pkg::sym_index(din.char_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				offset_q <= step_off;
			end
			if (din.ready) begin
				valid_s1 <= din.valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			hit_s1 <= sym.hit;
			pos_s1 <= sym.pos;
			off_s1 <= step_off;
		end
	end

	always_comb begin
		sp_sum = {1'b0, pos_s1} + 6'd30 - {1'b0, off_s1};
		sp     = (sp_sum >= 6'd30) ? rrc_pkg::POS_W'(sp_sum - 6'd30) : sp_sum[rrc_pkg::POS_W-1:0];
		p      = rotor[sp];
		r      = refl[p];
		q      = '0;
		for (int k = 0; k < rrc_pkg::SYMBOLS; k++) begin
			if (rotor[k] == r) begin
				q = rrc_pkg::POS_W'(k);
			end
		end
		q_sum   = {1'b0, q} + {1'b0, off_s1};
		out_pos = (q_sum >= 6'd30) ? rrc_pkg::POS_W'(q_sum - 6'd30) : q_sum[rrc_pkg::POS_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			invalid_s2 <= !hit_s1;
			char_s2    <= hit_s1 ? rrc_pkg::sym_char(out_pos) : '0;
		end
	end

	assign dout.valid    = valid_s2;
	assign dout.char_out = char_s2;
	assign dout.invalid  = invalid_s2;

	a_offset_range: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= rrc_pkg::LAST_POS)
		else $error("rotor offset left the alphabet range");

	a_restart_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && din.restart |=> offset_q == 5'd1)
		else $error("restart did not leave the offset at one");

	a_offset_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && !din.restart && offset_q == rrc_pkg::LAST_POS |=> offset_q == '0)
		else $error("offset did not wrap to zero");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!din.ready |-> valid_s1 && valid_s2 && !dout.ready)
		else $error("input stalled with room in the pipeline");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && invalid_s2 |-> char_s2 == '0)
		else $error("invalid character produced a non-zero result");

endmodule

### rtl/rotor_reflector_cipher_top.sv
// Top level of the rotor and reflector cipher: register file and datapath.
// Each character is registered in the input stage, then its result in the result register, which drives dout.
// Throughput: one character per cycle while dout accepts results, set by the single registered lookup and search pass.
// Reset: arst_n clears the rotor offset, all table registers and the pipeline valid flags.
// Depends on rrc_pkg, rrc_channels, rrc_cfg_regs and rrc_datapath.
`timescale 1ns / 1ps

module rotor_reflector_cipher_top (
	input logic        clk,
	input logic        arst_n,
	rrc_in_if.sink     din,
	rrc_out_if.source  dout,
	rrc_cfg_if.sink    cfg
);

	rrc_pkg::table_t rotor;
	rrc_pkg::table_t refl;

	rrc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rotor  (rotor),
		.refl   (refl)
	);

	rrc_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.rotor  (rotor),
		.refl   (refl)
	);

endmodule

### test/rotor_reflector_cipher_top_test.sv
// Self-checking testbench for rotor_reflector_cipher_top: directed and random character streams
// checked against an in-bench cipher predictor, with random idling and a long output hold-off.
// Depends on rrc_pkg, rrc_channels and the cipher RTL.
`timescale 1ns / 1ps

module rotor_reflector_cipher_top_test;

	localparam int CLK_HALF = 6;
	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF = 80;
	localparam int SETTLE = 4;
	localparam logic [rrc_pkg::IDX_W-1:0] CFG_SPARE_6 = 3'd6;
	localparam logic [rrc_pkg::IDX_W-1:0] CFG_SPARE_7 = 3'd7;
	localparam logic [8*rrc_pkg::SYMBOLS-1:0] ALPHABET = "ABCDEFGHIJKLMNOPQRSTUVWXYZ.,' ";

	typedef struct packed {
		logic [rrc_pkg::CHAR_W-1:0] char_out;
		logic                       invalid;
	} cipher_result_t;

	logic clk;
	logic arst_n;

	rrc_in_if  in_ch();
	rrc_out_if out_ch();
	rrc_cfg_if cfg_ch();

	rotor_reflector_cipher_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (in_ch),
		.dout   (out_ch),
		.cfg    (cfg_ch)
	);

	cipher_result_t            expected_results[$];
	logic [rrc_pkg::POS_W-1:0] rotor_model[rrc_pkg::SYMBOLS];
	logic [rrc_pkg::POS_W-1:0] refl_model[rrc_pkg::SYMBOLS];
	logic [rrc_pkg::POS_W-1:0] draft_rotor[rrc_pkg::SYMBOLS];
	logic [rrc_pkg::POS_W-1:0] draft_refl[rrc_pkg::SYMBOLS];
	int                        offset_model;
	int                        mismatches;
	int                        chars_sent;
	int                        invalid_sent;
	int                        results_checked;
	int                        config_writes;
	int                        quiet_cycles;
	bit                        idle_on;
	bit                        hold_request;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic logic [rrc_pkg::CHAR_W-1:0] symbol_at(input int pos);
		symbol_at = ALPHABET[8*(rrc_pkg::SYMBOLS-1-pos) +: 8];
	endfunction

	function automatic void store_reg(input logic [rrc_pkg::IDX_W-1:0] idx,
		input logic [rrc_pkg::REG_W-1:0] data);
		logic [rrc_pkg::POS_W-1:0] v;
		for (int k = 0; k < rrc_pkg::PER_REG; k++) begin
			v = data[rrc_pkg::POS_W*k +: rrc_pkg::POS_W];
			if (v >= rrc_pkg::SYMBOLS) begin
				v = rrc_pkg::POS_W'(v - rrc_pkg::SYMBOLS);
			end
			case (idx)
				rrc_pkg::CFG_ROTOR_0: rotor_model[k] = v;
				rrc_pkg::CFG_ROTOR_1: rotor_model[rrc_pkg::PER_REG+k] = v;
				rrc_pkg::CFG_ROTOR_2: rotor_model[2*rrc_pkg::PER_REG+k] = v;
				rrc_pkg::CFG_REFL_0:  refl_model[k] = v;
				rrc_pkg::CFG_REFL_1:  refl_model[rrc_pkg::PER_REG+k] = v;
				rrc_pkg::CFG_REFL_2:  refl_model[2*rrc_pkg::PER_REG+k] = v;
				default: ;
			endcase
		end
	endfunction

	function automatic void encipher_expected(input logic [rrc_pkg::CHAR_W-1:0] c,
		input logic rst);
		cipher_result_t            res;
		int                        pos;
		int                        sp;
		int                        q;
		logic [rrc_pkg::POS_W-1:0] r;
		pos = -1;
		for (int i = 0; i < rrc_pkg::SYMBOLS; i++) begin
			if (symbol_at(i) == c) begin
				pos = i;
			end
		end
		if (rst) begin
			offset_model = 0;
		end
		offset_model = (offset_model + 1) % rrc_pkg::SYMBOLS;
		if (pos < 0) begin
			res.char_out = '0;
			res.invalid = 1'b1;
			invalid_sent++;
		end else begin
			sp = (rrc_pkg::SYMBOLS + pos - offset_model) % rrc_pkg::SYMBOLS;
			r = refl_model[rotor_model[sp]];
			q = 0;
			for (int k = 0; k < rrc_pkg::SYMBOLS; k++) begin
				if (rotor_model[k] == r) begin
					q = k;
				end
			end
			res.char_out = symbol_at((q + offset_model) % rrc_pkg::SYMBOLS);
			res.invalid = 1'b0;
		end
		expected_results.push_back(res);
	endfunction

	function automatic logic [rrc_pkg::REG_W-1:0] draft_reg(input int reg_no);
		logic [rrc_pkg::REG_W-1:0] d;
		d = '0;
		for (int k = 0; k < rrc_pkg::PER_REG; k++) begin
			if (reg_no < int'(rrc_pkg::CFG_REFL_0)) begin
				d[rrc_pkg::POS_W*k +: rrc_pkg::POS_W] =
					draft_rotor[reg_no*rrc_pkg::PER_REG+k];
			end else begin
				d[rrc_pkg::POS_W*k +: rrc_pkg::POS_W] =
					draft_refl[(reg_no-int'(rrc_pkg::CFG_REFL_0))*rrc_pkg::PER_REG+k];
			end
		end
		draft_reg = d;
	endfunction

	function automatic void draw_wiring();
		int order[rrc_pkg::SYMBOLS];
		int j;
		int t;
		for (int i = 0; i < rrc_pkg::SYMBOLS; i++) begin
			draft_rotor[i] = rrc_pkg::POS_W'(i);
			order[i] = i;
		end
		for (int i = rrc_pkg::SYMBOLS-1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = int'(draft_rotor[i]);
			draft_rotor[i] = draft_rotor[j];
			draft_rotor[j] = rrc_pkg::POS_W'(t);
			j = $urandom_range(0, i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < rrc_pkg::SYMBOLS; i += 2) begin
			draft_refl[order[i]] = rrc_pkg::POS_W'(order[i+1]);
			draft_refl[order[i+1]] = rrc_pkg::POS_W'(order[i]);
		end
	endfunction

	task automatic write_reg(input logic [rrc_pkg::IDX_W-1:0] idx,
		input logic [rrc_pkg::REG_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		store_reg(idx, data);
		config_writes++;
	endtask

	task automatic end_writes();
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_tables();
		for (int i = int'(rrc_pkg::CFG_ROTOR_0); i <= int'(rrc_pkg::CFG_REFL_2); i++) begin
			write_reg(rrc_pkg::IDX_W'(i), draft_reg(i));
		end
		end_writes();
	endtask

	task automatic send_char(input logic [rrc_pkg::CHAR_W-1:0] c, input logic rst);
		int gap;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.char_in <= c;
		in_ch.restart <= rst;
		do @(posedge clk); while (!in_ch.ready);
		encipher_expected(c, rst);
		chars_sent++;
	endtask

	task automatic send_random_char(input int junk_pct, input int restart_pct);
		logic [rrc_pkg::CHAR_W-1:0] c;
		logic                       rst;
		if ($urandom_range(0, 99) < junk_pct) begin
			c = rrc_pkg::CHAR_W'($urandom_range(0, 255));
		end else begin
			c = symbol_at($urandom_range(0, rrc_pkg::SYMBOLS-1));
		end
		rst = ($urandom_range(0, 99) < restart_pct);
		send_char(c, rst);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// With every table entry at zero the rotor search always settles on the last position.
	task automatic test_reset_tables();
		send_char("A", 1'b0);
		send_char(" ", 1'b0);
		send_char("a", 1'b0);
		drain();
	endtask

	task automatic test_alphabet_extremes();
		for (int i = 0; i < rrc_pkg::SYMBOLS; i++) begin
			draft_rotor[i] = rrc_pkg::POS_W'((i * 7) % rrc_pkg::SYMBOLS);
			draft_refl[i] = rrc_pkg::POS_W'(rrc_pkg::SYMBOLS - 1 - i);
		end
		program_tables();
		send_char("A", 1'b1);
		send_char("Z", 1'b0);
		send_char(".", 1'b0);
		send_char(",", 1'b0);
		send_char("'", 1'b0);
		send_char(" ", 1'b0);
		send_char("@", 1'b0);
		send_char("[", 1'b1);
		send_char("!", 1'b0);
		send_char("-", 1'b0);
		send_char(8'h00, 1'b1);
		send_char(8'hFF, 1'b0);
		drain();
	endtask

	task automatic test_wrapped_entries();
		for (int i = int'(rrc_pkg::CFG_ROTOR_0); i <= int'(rrc_pkg::CFG_ROTOR_2); i++) begin
			write_reg(rrc_pkg::IDX_W'(i), '1);
		end
		for (int i = int'(rrc_pkg::CFG_REFL_0); i <= int'(rrc_pkg::CFG_REFL_2); i++) begin
			write_reg(rrc_pkg::IDX_W'(i), '0);
		end
		end_writes();
		send_char("B", 1'b0);
		send_char("Y", 1'b0);
		send_char(" ", 1'b0);
		drain();
		for (int i = 0; i < rrc_pkg::SYMBOLS; i++) begin
			draft_rotor[i] = (i % 3 == 0) ? 5'd30 :
				((i % 2 == 1) ? 5'd31 : rrc_pkg::POS_W'(i));
			draft_refl[i] = 5'd31;
		end
		program_tables();
		send_char("C", 1'b0);
		send_char("'", 1'b0);
		send_char("Q", 1'b1);
		drain();
		write_reg(CFG_SPARE_6, '1);
		write_reg(CFG_SPARE_7, rrc_pkg::REG_W'({$urandom(), $urandom()}));
		end_writes();
		send_char("D", 1'b0);
		send_char(",", 1'b0);
		send_char("X", 1'b0);
		drain();
	endtask

	task automatic test_random_stream();
		for (int phase = 0; phase < 9; phase++) begin
			draw_wiring();
			program_tables();
			idle_on = (phase % 3 != 2);
			repeat (120) send_random_char(12, 3);
			drain();
		end
		idle_on = 1'b1;
	endtask

	task automatic test_random_tables();
		for (int phase = 0; phase < 4; phase++) begin
			for (int i = int'(rrc_pkg::CFG_ROTOR_0); i <= int'(rrc_pkg::CFG_REFL_2); i++) begin
				write_reg(rrc_pkg::IDX_W'(i), rrc_pkg::REG_W'({$urandom(), $urandom()}));
			end
			write_reg(($urandom_range(0, 1) == 1) ? CFG_SPARE_6 : CFG_SPARE_7,
				rrc_pkg::REG_W'({$urandom(), $urandom()}));
			end_writes();
			repeat (60) send_random_char(20, 5);
			drain();
		end
	endtask

	task automatic test_backpressure();
		draw_wiring();
		program_tables();
		idle_on = 1'b0;
		hold_request = 1'b1;
		repeat (60) send_random_char(10, 2);
		drain();
		idle_on = 1'b1;
	endtask

	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
				hold_request = 1'b0;
			end
			stall = idle_on ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	always @(posedge clk) begin
		cipher_result_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: expected no result, actual char_out %h invalid %b", $time,
					out_ch.char_out, out_ch.invalid);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (out_ch.char_out !== want.char_out) begin
					$display("%0t: char_out expected %h actual %h", $time,
						want.char_out, out_ch.char_out);
					mismatches++;
				end
				if (out_ch.invalid !== want.invalid) begin
					$display("%0t: invalid expected %b actual %b", $time,
						want.invalid, out_ch.invalid);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
			|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.char_in = '0;
		in_ch.restart = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		idle_on = 1'b1;
		hold_request = 1'b0;
		quiet_cycles = 0;
		offset_model = 0;
		mismatches = 0;
		chars_sent = 0;
		invalid_sent = 0;
		results_checked = 0;
		config_writes = 0;
		for (int i = 0; i < rrc_pkg::SYMBOLS; i++) begin
			rotor_model[i] = '0;
			refl_model[i] = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_tables();
		test_alphabet_extremes();
		test_wrapped_entries();
		test_random_stream();
		test_random_tables();
		test_backpressure();
		repeat (SETTLE) @(posedge clk);
		$display("Enciphered %0d characters (%0d outside the alphabet), %0d results checked,",
			chars_sent, invalid_sent, results_checked);
		$display("%0d register writes across permuted, wrapped and random tables.",
			config_writes);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
